// File: sv/assert_macros.svh
// assertion macros for the bank controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implies");
// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/mmbc_pkg.sv
// types and constants shared by the bank controller modules
`timescale 1ns / 1ps

package mmbc_pkg;

  typedef enum logic [1:0] {
    CART_NONE  = 2'd0,
    CART_MBC1  = 2'd1,
    CART_MBC3  = 2'd2,
    CART_OTHER = 2'd3
  } cart_kind_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_BOOT = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_INT  = 3'd3,
    TGT_CRAM = 3'd4,
    TGT_DIRS = 3'd5,
    TGT_KEYS = 3'd6,
    TGT_FF   = 3'd7
  } target_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [15:0] ADDR_P1        = 16'hFF00;
  localparam logic [15:0] ADDR_DIV       = 16'hFF04;
  localparam logic [15:0] ADDR_LY        = 16'hFF44;
  localparam logic [15:0] ADDR_DMA       = 16'hFF46;
  localparam logic [15:0] ADDR_BOOT_EXIT = 16'hFF50;
  localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
  localparam logic [15:0] ADDR_BANKSEL   = 16'h2000;
  localparam logic [15:0] ADDR_ROMX      = 16'h4000;
  localparam logic [15:0] ADDR_MODESEL   = 16'h6000;
  localparam logic [15:0] ADDR_VRAM      = 16'h8000;
  localparam logic [15:0] ADDR_CRAM      = 16'hA000;
  localparam logic [15:0] ADDR_WRAM      = 16'hC000;
  localparam logic [15:0] ADDR_ECHO      = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_END  = 16'hFE00;
  localparam logic [15:0] ADDR_WRAM_TOP  = 16'hDE00;
  localparam logic [15:0] MIRROR_OFFSET  = 16'h2000;

  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0] P1_WRITE_MASK  = 8'hF0;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    target_t     target;
    logic [20:0] mapped_address;
    logic        write_enable;
    logic [7:0]  out_data;
    logic        mirror_valid;
    logic [15:0] mirror_address;
    logic        dma_start;
  } rsp_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_enable;
    logic       boot_active;
    logic [1:0] joypad_select;
  } bank_state_t;

  localparam bank_state_t BANK_STATE_RESET = '{
    rom_bank:      7'd1,
    ram_bank:      2'd0,
    ram_enable:    1'b0,
    boot_active:   1'b1,
    joypad_select: 2'b11
  };

endpackage

// File: sv/handheld_memory_map_bank_controller.sv
// bank controller top level: input register, decode, result register
// flow: an accepted request is held in the input register, and its response is loaded
// into the result register once that register is empty or being taken
// throughput: one transaction per cycle unless the response stalls; the result register frees the input
// register whenever the response is empty or being taken
// reset: synchronous, clears both valid bits, cart kind to no controller,
// rom bank 1, ram bank 0, ram disabled, boot rom overlaid, joypad select high
`timescale 1ns / 1ps
`include "assert_macros.svh"

module handheld_memory_map_bank_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mmbc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mmbc_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_data
);
  import mmbc_pkg::*;

  logic        s1_valid;
  req_t        s1_req;
  logic        advance;
  rsp_t        rsp_next;
  cart_kind_t  cart_kind;
  bank_state_t state;
  bank_state_t state_next;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req <= req;
    end
  end

  mmbc_decode u_decode (
    .req        (s1_req),
    .cart_kind  (cart_kind),
    .state      (state),
    .rsp        (rsp_next),
    .state_next (state_next)
  );

  // state moves with the transaction that leaves the input register
  mmbc_state u_state (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .update     (advance),
    .state_next (state_next),
    .cart_kind  (cart_kind),
    .state      (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_NEXT(a_boot_stays_off, clk, rst, !state.boot_active, !state.boot_active)
  `ASSERT_IMPLIES(a_we_target, clk, rst, rsp_valid && rsp.write_enable, rsp.target == TGT_INT || rsp.target == TGT_CRAM)
  `ASSERT_IMPLIES(a_mirror_we, clk, rst, rsp_valid && rsp.mirror_valid, rsp.write_enable && rsp.target == TGT_INT)
  `ASSERT_IMPLIES(a_dma_alone, clk, rst, rsp_valid && rsp.dma_start, !rsp.write_enable && rsp.target == TGT_NONE)

endmodule

// File: sv/mmbc_state.sv
// cartridge kind register and bank/enable/joypad state
`timescale 1ns / 1ps

module mmbc_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_data,
  input  logic                 update,
  input  mmbc_pkg::bank_state_t state_next,
  output mmbc_pkg::cart_kind_t cart_kind,
  output mmbc_pkg::bank_state_t state
);
  import mmbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_kind <= CART_NONE;
    end else if (cfg_write) begin
      cart_kind <= cart_kind_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BANK_STATE_RESET;
    end else if (update) begin
      state <= state_next;
    end
  end

endmodule

// File: sv/mmbc_decode.sv
// access decode: result fields and next bank state for one bus transaction
`timescale 1ns / 1ps

module mmbc_decode (
  input  mmbc_pkg::req_t        req,
  input  mmbc_pkg::cart_kind_t  cart_kind,
  input  mmbc_pkg::bank_state_t state,
  output mmbc_pkg::rsp_t        rsp,
  output mmbc_pkg::bank_state_t state_next
);
  import mmbc_pkg::*;

  logic [15:0] a;
  logic [7:0]  d;
  logic [6:0]  romx_bank;
  logic [20:0] romx_addr;
  logic [20:0] cram_addr;

  assign a = req.address;
  assign d = req.write_data;

  // banks 0 and 1 both map the switchable window to bank 1
  assign romx_bank = (state.rom_bank > 7'd1) ? state.rom_bank : 7'd1;
  assign romx_addr = {romx_bank, a[13:0]};
  assign cram_addr = {6'd0, state.ram_bank, a[12:0]};

  always_comb begin
    rsp        = '0;
    rsp.target = TGT_NONE;
    state_next = state;
    if (req.mode == MODE_READ) begin
      if (a < ADDR_BOOT_END && state.boot_active) begin
        rsp.target         = TGT_BOOT;
        rsp.mapped_address = {5'd0, a};
      end else if (a < ADDR_ROMX) begin
        rsp.target         = TGT_ROM;
        rsp.mapped_address = {5'd0, a};
      end else if (a < ADDR_VRAM) begin
        rsp.target         = TGT_ROM;
        rsp.mapped_address = romx_addr;
      end else if (a < ADDR_CRAM) begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
      end else if (a < ADDR_WRAM) begin
        if (cart_kind == CART_NONE) begin
          rsp.target         = TGT_INT;
          rsp.mapped_address = {5'd0, a};
        end else if (state.ram_enable) begin
          rsp.target         = TGT_CRAM;
          rsp.mapped_address = cram_addr;
        end
      end else if (a == ADDR_P1) begin
        if (!state.joypad_select[0]) begin
          rsp.target = TGT_DIRS;
        end else if (!state.joypad_select[1]) begin
          rsp.target = TGT_KEYS;
        end else begin
          rsp.target = TGT_FF;
        end
      end else begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
      end
    end else begin
      if (a == ADDR_DMA) begin
        rsp.dma_start = 1'b1;
        rsp.out_data  = d;
      end else if (a == ADDR_P1) begin
        state_next.joypad_select = d[5:4];
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
        rsp.out_data       = d & P1_WRITE_MASK;
      end else if (a == ADDR_DIV) begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
      end else if (a == ADDR_BOOT_EXIT) begin
        state_next.boot_active = 1'b0;
      end else if (a < ADDR_BANKSEL) begin
        state_next.ram_enable = ((d & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
      end else if (a < ADDR_ROMX) begin
        case (cart_kind)
          CART_MBC1: begin
            state_next.rom_bank = (d[3:0] == 4'd0) ? 7'd1 : {3'd0, d[3:0]};
          end
          CART_MBC3: begin
            state_next.rom_bank = d[6:0];
          end
          default: begin
            state_next.rom_bank = 7'd1;
          end
        endcase
      end else if (a < ADDR_MODESEL) begin
        if (cart_kind == CART_MBC1 || cart_kind == CART_MBC3) begin
          state_next.ram_bank = d[1:0];
        end
      end else if (a < ADDR_VRAM) begin
        if (cart_kind == CART_MBC1) begin
          state_next.rom_bank = 7'd0;
        end
      end else if (a >= ADDR_ECHO && a < ADDR_ECHO_END) begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
        rsp.out_data       = d;
        rsp.mirror_valid   = 1'b1;
        rsp.mirror_address = a - MIRROR_OFFSET;
      end else if (a >= ADDR_WRAM && a < ADDR_ECHO) begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
        rsp.out_data       = d;
        // the top of work ram has no echo copy
        if (a < ADDR_WRAM_TOP) begin
          rsp.mirror_valid   = 1'b1;
          rsp.mirror_address = a + MIRROR_OFFSET;
        end
      end else if (a >= ADDR_CRAM && a < ADDR_WRAM) begin
        if (state.ram_enable) begin
          rsp.target         = TGT_CRAM;
          rsp.mapped_address = cram_addr;
          rsp.write_enable   = 1'b1;
          rsp.out_data       = d;
        end
      end else if (a == ADDR_LY) begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
      end else begin
        rsp.target         = TGT_INT;
        rsp.mapped_address = {5'd0, a};
        rsp.write_enable   = 1'b1;
        rsp.out_data       = d;
      end
    end
  end

endmodule
